>>> hw/rtl/rrc_pkg.sv
// Package for the receive ring consumer: types, register codes, reset values
// and the fixed ring constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rrc_pkg;

  localparam int PAGE_BYTES  = 256;
  localparam int HDR_BYTES   = 4;
  localparam int CRC_BYTES   = 4;
  localparam int MIN_FRAME   = 60;
  localparam int QUEUE_DEPTH = 4;

  // A stored low byte above this value borrows one page from the distance.
  localparam logic [7:0]  LEN_LOW_MAX   = 8'(PAGE_BYTES - HDR_BYTES);
  localparam logic [10:0] FRAME_LEN_MAX = 11'h7FF;
  localparam logic [3:0]  STATUS_GOOD   = 4'h1;

  localparam logic [7:0]  RING_START_RST = 8'd70;
  localparam logic [7:0]  RING_STOP_RST  = 8'd128;
  localparam logic [10:0] MAX_FRAME_RST  = 11'd1514;
  localparam logic [4:0]  HOST_SLOTS_RST = 5'd16;

  typedef enum logic [1:0] {
    CFG_RING_START = 2'd0,
    CFG_RING_STOP  = 2'd1,
    CFG_MAX_FRAME  = 2'd2,
    CFG_HOST_SLOTS = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OUT_EMPTY      = 2'd0,
    OUT_DELIVERED  = 2'd1,
    OUT_DROPPED    = 2'd2,
    OUT_RING_RESET = 2'd3
  } outcome_t;

  typedef struct packed {
    logic [7:0]  ring_start;
    logic [7:0]  ring_stop;
    logic [10:0] max_frame;
    logic [4:0]  host_slots;
  } cfg_t;

  // Classified header handed from the front to the back.
  typedef struct packed {
    outcome_t    outcome;
    logic [10:0] frame_len;
    logic [7:0]  cur_page;
    logic [7:0]  next_page;
    logic [3:0]  host_slot;
  } item_t;

endpackage

`default_nettype wire

>>> hw/rtl/nic_rx_ring_consumer_core.sv
// Top level of the receive ring consumer: configuration registers, front end,
// header queue and back end. Depends on rrc_pkg, rrc_front, rrc_queue, rrc_back.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one packet header per clock cycle while full is low and
// returns one result per header, in order. A header is classified in the
// cycle it is accepted (the pointer and slot index update at that edge, so
// the next header may follow at once); it is written into the header queue,
// then moves to the result register once that register is empty or popped,
// and its result appears on the out_ ports. While results are not popped, up
// to QUEUE_DEPTH + 1 headers are absorbed before full rises. Configuration
// writes are always ready and are meant for idle time.
module nic_rx_ring_consumer_core #(
  parameter int QUEUE_DEPTH = rrc_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_write_page,
  input  wire logic [7:0]  in_hdr_status,
  input  wire logic [7:0]  in_hdr_next_page,
  input  wire logic [7:0]  in_hdr_len_low,
  input  wire logic        in_slot_free,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       out_outcome,
  output logic [10:0]      out_frame_len,
  output logic [15:0]      out_span1_addr,
  output logic [10:0]      out_span1_len,
  output logic [15:0]      out_span2_addr,
  output logic [10:0]      out_span2_len,
  output logic [7:0]       out_boundary_page,
  output logic [3:0]       out_host_slot
);

  rrc_pkg::cfg_t  cfg_r;
  rrc_pkg::item_t front_item, q_item;
  logic           accept, q_empty, q_pop;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ring_start <= rrc_pkg::RING_START_RST;
      cfg_r.ring_stop  <= rrc_pkg::RING_STOP_RST;
      cfg_r.max_frame  <= rrc_pkg::MAX_FRAME_RST;
      cfg_r.host_slots <= rrc_pkg::HOST_SLOTS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rrc_pkg::cfg_idx_t'(cfg_index))
        rrc_pkg::CFG_RING_START: cfg_r.ring_start <= cfg_data[7:0];
        rrc_pkg::CFG_RING_STOP:  cfg_r.ring_stop  <= cfg_data[7:0];
        rrc_pkg::CFG_MAX_FRAME:  cfg_r.max_frame  <= cfg_data;
        rrc_pkg::CFG_HOST_SLOTS: cfg_r.host_slots <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  rrc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .accept        (accept),
    .write_page    (in_write_page),
    .hdr_status    (in_hdr_status),
    .hdr_next_page (in_hdr_next_page),
    .hdr_len_low   (in_hdr_len_low),
    .slot_free     (in_slot_free),
    .item          (front_item)
  );

  rrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .wdata (front_item),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

  rrc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .pop               (pop),
    .empty             (empty),
    .out_outcome       (out_outcome),
    .out_frame_len     (out_frame_len),
    .out_span1_addr    (out_span1_addr),
    .out_span1_len     (out_span1_len),
    .out_span2_addr    (out_span2_addr),
    .out_span2_len     (out_span2_len),
    .out_boundary_page (out_boundary_page),
    .out_host_slot     (out_host_slot)
  );

endmodule

`default_nettype wire

>>> hw/rtl/rrc_front.sv
// Front end of the receive ring consumer: classifies each header and owns the
// next-packet pointer and host slot index. Depends on rrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrc_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire rrc_pkg::cfg_t cfg,
  input  wire logic         accept,
  input  wire logic [7:0]   write_page,
  input  wire logic [7:0]   hdr_status,
  input  wire logic [7:0]   hdr_next_page,
  input  wire logic [7:0]   hdr_len_low,
  input  wire logic         slot_free,
  output rrc_pkg::item_t    item
);

  logic [7:0]  next_page_r, next_page_nxt;
  logic [3:0]  slot_idx_r, slot_idx_nxt;

  logic [7:0]  dist_fwd, dist_wrap, pages0, pages;
  logic [15:0] raw, len;
  logic        under, bad, good;
  logic [4:0]  slot_inc;

  always_comb begin
    dist_fwd  = hdr_next_page - next_page_r - 8'd1;
    dist_wrap = cfg.ring_stop - next_page_r + hdr_next_page - cfg.ring_start - 8'd1;
    pages0    = (hdr_next_page > next_page_r) ? dist_fwd : dist_wrap;
    pages     = (hdr_len_low > rrc_pkg::LEN_LOW_MAX) ? pages0 - 8'd1 : pages0;
    raw       = {pages, hdr_len_low};
    under     = raw < 16'(rrc_pkg::CRC_BYTES);
    len       = raw - 16'(rrc_pkg::CRC_BYTES);
    bad       = under || (hdr_next_page < cfg.ring_start) || (hdr_next_page >= cfg.ring_stop)
                || (len < 16'(rrc_pkg::MIN_FRAME)) || (len > {5'd0, cfg.max_frame});
    good      = (hdr_status[3:0] == rrc_pkg::STATUS_GOOD) && slot_free;
    slot_inc  = {1'b0, slot_idx_r} + 5'd1;
  end

  always_comb begin
    item.cur_page  = next_page_r;
    item.next_page = hdr_next_page;
    item.host_slot = 4'd0;
    item.frame_len = len[10:0];
    next_page_nxt  = next_page_r;
    slot_idx_nxt   = slot_idx_r;
    if (write_page == next_page_r) begin
      item.outcome   = rrc_pkg::OUT_EMPTY;
      item.frame_len = 11'd0;
    end else if (bad) begin
      item.outcome   = rrc_pkg::OUT_RING_RESET;
      if (under) begin
        item.frame_len = 11'd0;
      end else if (len > {5'd0, rrc_pkg::FRAME_LEN_MAX}) begin
        item.frame_len = rrc_pkg::FRAME_LEN_MAX;
      end
      next_page_nxt  = cfg.ring_start;
    end else if (good) begin
      item.outcome   = rrc_pkg::OUT_DELIVERED;
      item.host_slot = slot_idx_r;
      next_page_nxt  = hdr_next_page;
      // The index wraps at the slot count and also past the top of its range.
      if (slot_inc >= cfg.host_slots || slot_inc[4]) begin
        slot_idx_nxt = 4'd0;
      end else begin
        slot_idx_nxt = slot_inc[3:0];
      end
    end else begin
      item.outcome   = rrc_pkg::OUT_DROPPED;
      next_page_nxt  = hdr_next_page;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_page_r <= rrc_pkg::RING_START_RST;
      slot_idx_r  <= 4'd0;
    end else if (accept) begin
      next_page_r <= next_page_nxt;
      slot_idx_r  <= slot_idx_nxt;
    end
  end

  a_reset_pointer: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && item.outcome == rrc_pkg::OUT_RING_RESET)
      |=> (next_page_r == $past(cfg.ring_start)))
    else $error("ring reset did not return the pointer to the ring start");

endmodule

`default_nettype wire

>>> hw/rtl/rrc_queue.sv
// Short queue of classified headers between the front and the back end.
// Depends on rrc_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module rrc_queue #(
  parameter int DEPTH = rrc_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire rrc_pkg::item_t wdata,
  output logic                full,
  input  wire logic           pop,
  output rrc_pkg::item_t      rdata,
  output logic                empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rrc_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count exceeds its depth");

  a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue count did not grow on a lone push");

endmodule

`default_nettype wire

>>> hw/rtl/rrc_back.sv
// Back end of the receive ring consumer: turns a classified header into copy
// spans and a boundary page, held in the result register. Depends on rrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rrc_pkg::cfg_t  cfg,
  input  wire logic           q_empty,
  input  wire rrc_pkg::item_t q_item,
  output logic                q_pop,
  input  wire logic           pop,
  output logic                empty,
  output logic [1:0]          out_outcome,
  output logic [10:0]         out_frame_len,
  output logic [15:0]         out_span1_addr,
  output logic [10:0]         out_span1_len,
  output logic [15:0]         out_span2_addr,
  output logic [10:0]         out_span2_len,
  output logic [7:0]          out_boundary_page,
  output logic [3:0]          out_host_slot
);

  logic                valid_r;
  rrc_pkg::outcome_t   outcome_r;
  logic [10:0]         frame_len_r, span1_len_r, span2_len_r;
  logic [15:0]         span1_addr_r, span2_addr_r;
  logic [7:0]          boundary_r;
  logic [3:0]          host_slot_r;

  logic [16:0] data_addr, ring_end, data_end, first;
  logic [10:0] span1_len_nxt, span2_len_nxt;
  logic [15:0] span1_addr_nxt, span2_addr_nxt;
  logic [7:0]  boundary_nxt;

  assign q_pop = !q_empty && (!valid_r || pop);
  assign empty = !valid_r;

  always_comb begin
    data_addr = {1'b0, q_item.cur_page, 8'd0} + 17'(rrc_pkg::HDR_BYTES);
    ring_end  = {1'b0, cfg.ring_stop, 8'd0};
    data_end  = data_addr + {6'd0, q_item.frame_len};
    first     = {6'd0, q_item.frame_len};
    // A frame that reaches the ring end continues at the ring start.
    if (data_end >= ring_end) begin
      first = (data_addr >= ring_end) ? 17'd0 : ring_end - data_addr;
    end
    span1_addr_nxt = 16'd0;
    span1_len_nxt  = 11'd0;
    span2_addr_nxt = 16'd0;
    span2_len_nxt  = 11'd0;
    if (q_item.outcome == rrc_pkg::OUT_DELIVERED) begin
      span1_addr_nxt = data_addr[15:0];
      span1_len_nxt  = first[10:0];
      span2_addr_nxt = {cfg.ring_start, 8'd0};
      span2_len_nxt  = q_item.frame_len - first[10:0];
    end
  end

  always_comb begin
    unique case (q_item.outcome)
      rrc_pkg::OUT_EMPTY:      boundary_nxt = 8'd0;
      rrc_pkg::OUT_RING_RESET: boundary_nxt = cfg.ring_stop - 8'd1;
      default: begin
        boundary_nxt = (q_item.next_page <= cfg.ring_start) ? cfg.ring_stop - 8'd1
                                                            : q_item.next_page - 8'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      outcome_r    <= q_item.outcome;
      frame_len_r  <= q_item.frame_len;
      span1_addr_r <= span1_addr_nxt;
      span1_len_r  <= span1_len_nxt;
      span2_addr_r <= span2_addr_nxt;
      span2_len_r  <= span2_len_nxt;
      boundary_r   <= boundary_nxt;
      host_slot_r  <= q_item.host_slot;
    end
  end

  assign out_outcome       = outcome_r;
  assign out_frame_len     = frame_len_r;
  assign out_span1_addr    = span1_addr_r;
  assign out_span1_len     = span1_len_r;
  assign out_span2_addr    = span2_addr_r;
  assign out_span2_len     = span2_len_r;
  assign out_boundary_page = boundary_r;
  assign out_host_slot     = host_slot_r;

  a_span_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && outcome_r == rrc_pkg::OUT_DELIVERED)
      |-> ({1'b0, span1_len_r} + {1'b0, span2_len_r} == {1'b0, frame_len_r}))
    else $error("copy spans do not add up to the frame length");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && outcome_r == rrc_pkg::OUT_EMPTY)
      |-> (frame_len_r == 11'd0 && boundary_r == 8'd0 && host_slot_r == 4'd0))
    else $error("ring empty result carries nonzero fields");

endmodule

`default_nettype wire
